>>> src/depthwise_conv_maxpool_engine_unit_defines.svh
// Assertion macros for the depthwise convolution / max pooling engine checks.
`ifndef DEPTHWISE_CONV_MAXPOOL_ENGINE_UNIT_DEFINES_SVH
`define DEPTHWISE_CONV_MAXPOOL_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dcm check failed");

// Next-cycle implication, disabled during reset.
`define DCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dcm check failed");

`endif

>>> src/dcm_pkg.sv
// Shared types, codes and defaults for the depthwise convolution / max pooling engine.
package dcm_pkg;

  localparam int DEF_MAX_ROWS     = 32;
  localparam int DEF_MAX_COLS     = 32;
  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_MAX_WINDOW   = 8;

  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 14;
  localparam int VALUE_W  = 16;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int DIM_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  // Pool start value in Q8.8
  localparam logic signed [VALUE_W-1:0] POOL_START = -16'sd25600;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WR_FEAT = 2'd0,
    ACT_WR_FILT = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_READ    = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_READ = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2,
    ST_NONE = 2'd3
  } status_t;

  localparam logic [1:0] MODE_CONV   = 2'd0;
  localparam logic [1:0] MODE_BORDER = 2'd1;
  localparam logic [1:0] MODE_POOL   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_ROWS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_COLS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_ROWS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_COLS = 3'd5;

endpackage

>>> src/dcm_ifs.sv
// Handshake channel interfaces for command, response and configuration.
interface dcm_cmd_if import dcm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [INDEX_W-1:0]  index;
  logic signed [VALUE_W-1:0] value;
  modport source (output valid, action, index, value, input ready);
  modport sink   (input valid, action, index, value, output ready);
endinterface

interface dcm_rsp_if import dcm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic signed [DATA_W-1:0] data;
  logic [STATUS_W-1:0] status;
  logic [DIM_W-1:0]    out_rows;
  logic [DIM_W-1:0]    out_cols;
  modport source (output valid, data, status, out_rows, out_cols, input ready);
  modport sink   (input valid, data, status, out_rows, out_cols, output ready);
endinterface

interface dcm_cfg_if import dcm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/depthwise_conv_maxpool_engine_unit.sv
// Depthwise convolution / max pooling engine: top level with stores and sequencer.
//
// The block holds a feature volume, per-channel filters and a result volume, all
// addressed linearly (channel, then row, then column, at fixed pitches). A feature
// or filter write gives no response item. A read passes through the registered
// result-memory read, then the response item waits in the output register. A
// compute item runs a small sequencer: range checks, then a shared subtract-and-count
// divider for rows and then for columns, then per output element win_rows*win_cols
// taps on the single feature/filter read port and multiplier, then a drain of the
// multiply-accumulate pipeline and a store of the element. No item is accepted
// while it runs. Stores are not cleared after reset; configuration writes are always
// taken and must only be made while the block is idle.
module depthwise_conv_maxpool_engine_unit import dcm_pkg::*; #(
  parameter int MAX_ROWS     = DEF_MAX_ROWS,
  parameter int MAX_COLS     = DEF_MAX_COLS,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_WINDOW   = DEF_MAX_WINDOW
) (
  input  logic      clk,
  input  logic      rst,
  dcm_cmd_if.sink   cmd,
  dcm_rsp_if.source rsp,
  dcm_cfg_if.sink   cfg
);

  localparam int FEAT_PLANE = MAX_ROWS * MAX_COLS;
  localparam int FEAT_DEPTH = MAX_CHANNELS * FEAT_PLANE;
  localparam int FILT_PLANE = MAX_WINDOW * MAX_WINDOW;
  localparam int FILT_DEPTH = MAX_CHANNELS * FILT_PLANE;
  localparam int RES_PITCH  = MAX_COLS + 1;
  localparam int RES_PLANE  = (MAX_ROWS + 1) * RES_PITCH;
  localparam int RES_DEPTH  = MAX_CHANNELS * RES_PLANE;
  localparam int FEAT_AW    = $clog2(FEAT_DEPTH);
  localparam int FILT_AW    = $clog2(FILT_DEPTH);
  localparam int RES_AW     = $clog2(RES_DEPTH);
  localparam int ACC_W      = DATA_W + 1 + $clog2(FILT_PLANE);
  localparam int CW         = 8;  // bordered coordinate: base below 65 plus window tap
  localparam int QW         = 7;  // extent and quotient, up to 64

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_READ  = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_DIV_R = 9'b000001000,
    S_DIV_C = 9'b000010000,
    S_TAP   = 9'b000100000,
    S_DRAIN = 9'b001000000,
    S_STORE = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers
  logic [1:0] op_mode;
  logic [5:0] in_rows, in_cols;
  logic [3:0] channels, win_rows, win_cols;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode  <= MODE_CONV;
      in_rows  <= 6'd1;
      in_cols  <= 6'd1;
      channels <= 4'd1;
      win_rows <= 4'd2;
      win_cols <= 4'd2;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_OP_MODE:  op_mode  <= cfg.data[1:0];
        REG_IN_ROWS:  in_rows  <= cfg.data;
        REG_IN_COLS:  in_cols  <= cfg.data;
        REG_CHANNELS: channels <= cfg.data[3:0];
        REG_WIN_ROWS: win_rows <= cfg.data[3:0];
        REG_WIN_COLS: win_cols <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  // Accept only when idle and the output register is free or being emptied
  logic cmd_acc;
  assign cmd.ready = (state == S_IDLE) && (!rsp.valid || rsp.ready);
  assign cmd_acc   = cmd.valid && cmd.ready;

  // Shape derived from configuration
  logic           is_pool, border;
  logic [3:0]     sr, sc;
  logic [QW-1:0]  er, ec;
  logic           basic_ok;

  assign is_pool = (op_mode == MODE_POOL);
  assign border  = (op_mode == MODE_BORDER);
  assign sr = is_pool ? win_rows : win_rows - 4'd1;
  assign sc = is_pool ? win_cols : win_cols - 4'd1;
  assign er = is_pool ? QW'(in_rows) : (border ? QW'(in_rows) + QW'(1) : QW'(in_rows) - QW'(1));
  assign ec = is_pool ? QW'(in_cols) : (border ? QW'(in_cols) + QW'(1) : QW'(in_cols) - QW'(1));

  always_comb begin
    basic_ok = 1'b1;
    if (op_mode > MODE_POOL) basic_ok = 1'b0;
    if (in_rows == 6'd0 || int'(in_rows) > MAX_ROWS) basic_ok = 1'b0;
    if (in_cols == 6'd0 || int'(in_cols) > MAX_COLS) basic_ok = 1'b0;
    if (channels == 4'd0 || int'(channels) > MAX_CHANNELS) basic_ok = 1'b0;
    if (win_rows == 4'd0 || int'(win_rows) > MAX_WINDOW) basic_ok = 1'b0;
    if (win_cols == 4'd0 || int'(win_cols) > MAX_WINDOW) basic_ok = 1'b0;
    // A convolution with a one-wide window has no stride
    if (!is_pool && (win_rows == 4'd1 || win_cols == 4'd1)) basic_ok = 1'b0;
  end

  // Sequencer counters
  logic [QW-1:0] rem, quo;
  logic [QW-1:0] orow, ocol;
  logic [3:0]    k;
  logic [QW-1:0] y, x;
  logic [CW-1:0] rbase, cbase;
  logic [3:0]    l, c;
  logic          drain;

  // Tap addressing
  logic [CW-1:0]      row, col, fr, fc;
  logic               tap_zero;
  logic [FEAT_AW-1:0] feat_raddr;
  logic [FILT_AW-1:0] filt_raddr;
  logic [RES_AW-1:0]  res_waddr;

  assign row = rbase + CW'(l);
  assign col = cbase + CW'(c);
  assign tap_zero = border && (row == '0 || col == '0 ||
                               row == CW'(in_rows) + CW'(1) || col == CW'(in_cols) + CW'(1));
  assign fr = border ? row - CW'(1) : row;
  assign fc = border ? col - CW'(1) : col;
  assign feat_raddr = FEAT_AW'(int'(k) * FEAT_PLANE + int'(fr) * MAX_COLS + int'(fc));
  assign filt_raddr = FILT_AW'(int'(k) * FILT_PLANE + int'(l) * MAX_WINDOW + int'(c));
  assign res_waddr  = RES_AW'(int'(k) * RES_PLANE + int'(y) * RES_PITCH + int'(x));

  // Memories
  logic signed [VALUE_W-1:0] feat_mem [FEAT_DEPTH];
  logic signed [VALUE_W-1:0] filt_mem [FILT_DEPTH];
  logic signed [DATA_W-1:0]  res_mem  [RES_DEPTH];
  logic signed [VALUE_W-1:0] feat_rdata, filt_rdata;
  logic signed [DATA_W-1:0]  res_rdata;
  logic signed [DATA_W-1:0]  res_wdata;
  logic                      res_we;

  always_ff @(posedge clk) begin
    if (cmd_acc && cmd.action == ACT_WR_FEAT && int'(cmd.index) < FEAT_DEPTH) begin
      feat_mem[FEAT_AW'(cmd.index)] <= cmd.value;
    end
    feat_rdata <= feat_mem[feat_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd_acc && cmd.action == ACT_WR_FILT && int'(cmd.index) < FILT_DEPTH) begin
      filt_mem[FILT_AW'(cmd.index)] <= cmd.value;
    end
    filt_rdata <= filt_mem[filt_raddr];
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[res_waddr] <= res_wdata;
    end
    res_rdata <= res_mem[RES_AW'(cmd.index)];
  end

  // Multiply-accumulate / running-max pipeline
  logic                      v1, z1, v2;
  logic signed [DATA_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [VALUE_W-1:0] pool_max;
  logic signed [DATA_W-1:0]  conv_sat, pool_q;

  assign conv_sat = (acc > SAT_HI) ? DATA_W'(SAT_HI) :
                    (acc < SAT_LO) ? DATA_W'(SAT_LO) : DATA_W'(acc);
  assign pool_q   = {{8{pool_max[VALUE_W-1]}}, pool_max, 8'h00};
  assign res_we    = (state == S_STORE);
  assign res_wdata = is_pool ? pool_q : conv_sat;

  // Response register
  logic                      rsp_valid;
  logic signed [DATA_W-1:0]  rsp_data;
  status_t                   rsp_status;
  logic                      read_oob;
  logic [DIM_W-1:0]          result_rows, result_cols;

  assign rsp.valid    = rsp_valid;
  assign rsp.data     = rsp_data;
  assign rsp.status   = rsp_status;
  assign rsp.out_rows = result_rows;
  assign rsp.out_cols = result_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      result_rows <= '0;
      result_cols <= '0;
      v1          <= 1'b0;
      v2          <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;

      // Pipeline advances every cycle; keep the product signed
      v1 <= (state == S_TAP);
      z1 <= tap_zero;
      v2 <= v1;
      prod <= z1 ? DATA_W'(0) : feat_rdata * filt_rdata;
      if (v1 && !z1 && feat_rdata > pool_max) pool_max <= feat_rdata;
      if (v2) acc <= acc + {{(ACC_W-DATA_W){prod[DATA_W-1]}}, prod};

      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            read_oob <= !(int'(cmd.index) < RES_DEPTH);
            case (cmd.action)
              ACT_READ:    state <= S_READ;
              ACT_COMPUTE: state <= S_CHECK;
              default:     state <= S_IDLE;
            endcase
          end
        end
        S_READ: begin
          rsp_valid  <= 1'b1;
          rsp_data   <= read_oob ? '0 : res_rdata;
          rsp_status <= ST_READ;
          state      <= S_IDLE;
        end
        S_CHECK: begin
          rsp_data <= '0;
          if (!basic_ok) begin
            rsp_status <= ST_ERR;
            state      <= S_RESP;
          end else begin
            rem   <= er;
            quo   <= '0;
            state <= S_DIV_R;
          end
        end
        S_DIV_R, S_DIV_C: begin
          // Shared divider: subtract the stride once per cycle
          if (rem >= QW'(state == S_DIV_R ? sr : sc)) begin
            rem <= rem - QW'(state == S_DIV_R ? sr : sc);
            quo <= quo + QW'(1);
          end else if (rem != '0) begin
            rsp_status <= ST_ERR;
            state      <= S_RESP;
          end else if (state == S_DIV_R) begin
            orow  <= quo;
            rem   <= ec;
            quo   <= '0;
            state <= S_DIV_C;
          end else begin
            ocol        <= quo;
            result_rows <= DIM_W'(orow);
            result_cols <= DIM_W'(quo);
            rsp_status  <= ST_DONE;
            k <= '0; y <= '0; x <= '0; l <= '0; c <= '0;
            rbase <= '0; cbase <= '0;
            acc <= '0;
            pool_max <= POOL_START;
            state <= (orow == '0 || quo == '0) ? S_RESP : S_TAP;
          end
        end
        S_TAP: begin
          if (c == win_cols - 4'd1) begin
            c <= '0;
            if (l == win_rows - 4'd1) begin
              l     <= '0;
              drain <= 1'b0;
              state <= S_DRAIN;
            end else begin
              l <= l + 4'd1;
            end
          end else begin
            c <= c + 4'd1;
          end
        end
        S_DRAIN: begin
          drain <= 1'b1;
          if (drain) state <= S_STORE;
        end
        S_STORE: begin
          // Element written this cycle; reset the accumulators and step the output
          acc      <= '0;
          pool_max <= POOL_START;
          state    <= S_TAP;
          if (x == ocol - QW'(1)) begin
            x     <= '0;
            cbase <= '0;
            if (y == orow - QW'(1)) begin
              y     <= '0;
              rbase <= '0;
              if (k == channels - 4'd1) begin
                state <= S_RESP;
              end else begin
                k <= k + 4'd1;
              end
            end else begin
              y     <= y + QW'(1);
              rbase <= rbase + CW'(sr);
            end
          end else begin
            x     <= x + QW'(1);
            cbase <= cbase + CW'(sc);
          end
        end
        S_RESP: begin
          rsp_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/dcm_checker.sv
// Port-level checker for the depthwise convolution / max pooling engine, with its bind.
`include "depthwise_conv_maxpool_engine_unit_defines.svh"

module dcm_checker import dcm_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [DATA_W-1:0]   rsp_data,
  input logic [STATUS_W-1:0] rsp_status
);

  // No new item is taken while a response item waits unconsumed
  `DCM_ASSERT_NOW(a_hold_while_rsp_waits, rsp_valid && !rsp_ready, !cmd_ready)
  `DCM_ASSERT_NOW(a_status_code, rsp_valid, rsp_status != ST_NONE)
  `DCM_ASSERT_NOW(a_data_zero_unless_read, rsp_valid && rsp_status != ST_READ, rsp_data == '0)
  `DCM_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind depthwise_conv_maxpool_engine_unit dcm_checker u_dcm_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_data   (rsp.data),
  .rsp_status (rsp.status)
);

>>> sim/tb_depthwise_conv_maxpool_engine_unit.sv
// Self-checking testbench for the depthwise convolution / max pooling engine.
module tb_depthwise_conv_maxpool_engine_unit;
  import dcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FEAT_PLANE = DEF_MAX_ROWS * DEF_MAX_COLS;
  localparam int FEAT_DEPTH = DEF_MAX_CHANNELS * FEAT_PLANE;
  localparam int FILT_PLANE = DEF_MAX_WINDOW * DEF_MAX_WINDOW;
  localparam int FILT_DEPTH = DEF_MAX_CHANNELS * FILT_PLANE;
  localparam int RES_PITCH  = DEF_MAX_COLS + 1;
  localparam int RES_PLANE  = (DEF_MAX_ROWS + 1) * RES_PITCH;
  localparam int RES_DEPTH  = DEF_MAX_CHANNELS * RES_PLANE;
  localparam int STALL_LIMIT = 400000;
  localparam int ITEM_TARGET = 1400;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic [STATUS_W-1:0]      status;
    logic [DIM_W-1:0]         rows;
    logic [DIM_W-1:0]         cols;
  } layer_rsp_t;

  // Mirror of the engine: operand and result stores, shape registers, and the
  // queue of responses still owed by the block.
  class conv_pool_scoreboard;
    logic signed [VALUE_W-1:0] feat_mem [FEAT_DEPTH];
    bit                        feat_ok  [FEAT_DEPTH];
    logic signed [VALUE_W-1:0] filt_mem [FILT_DEPTH];
    bit                        filt_ok  [FILT_DEPTH];
    logic signed [DATA_W-1:0]  res_mem  [RES_DEPTH];
    bit                        res_ok   [RES_DEPTH];
    logic [1:0] op_mode;
    logic [5:0] in_rows, in_cols;
    logic [3:0] channels, win_rows, win_cols;
    logic [DIM_W-1:0] res_rows, res_cols;
    layer_rsp_t owed_q[$];
    int errors, n_compute, n_shape_err, n_read;

    function new();
      op_mode = MODE_CONV; in_rows = 1; in_cols = 1; channels = 1;
      win_rows = 2; win_cols = 2; res_rows = 0; res_cols = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_OP_MODE:  op_mode  = d[1:0];
        REG_IN_ROWS:  in_rows  = d;
        REG_IN_COLS:  in_cols  = d;
        REG_CHANNELS: channels = d[3:0];
        REG_WIN_ROWS: win_rows = d[3:0];
        REG_WIN_COLS: win_cols = d[3:0];
        default: ;
      endcase
    endfunction

    // Shape rules of the layer; gives the output plane size when they hold.
    function bit shape_of(int op, int r, int c, int ch, int wr, int wc,
                          output int orow, output int ocol);
      int er, ec;
      orow = 0; ocol = 0;
      if (op > MODE_POOL) return 0;
      if (r < 1 || r > DEF_MAX_ROWS || c < 1 || c > DEF_MAX_COLS) return 0;
      if (ch < 1 || ch > DEF_MAX_CHANNELS) return 0;
      if (wr < 1 || wr > DEF_MAX_WINDOW || wc < 1 || wc > DEF_MAX_WINDOW) return 0;
      if (op == MODE_POOL) begin
        if (r % wr != 0 || c % wc != 0) return 0;
        orow = r / wr; ocol = c / wc;
        return 1;
      end
      if (wr < 2 || wc < 2) return 0;
      er = (op == MODE_BORDER) ? r + 1 : r - 1;
      ec = (op == MODE_BORDER) ? c + 1 : c - 1;
      if (er % (wr - 1) != 0 || ec % (wc - 1) != 0) return 0;
      orow = er / (wr - 1); ocol = ec / (wc - 1);
      return 1;
    endfunction

    function bit cur_shape(output int orow, output int ocol);
      return shape_of(op_mode, in_rows, in_cols, channels, win_rows, win_cols, orow, ocol);
    endfunction

    function int pixel(int k, int r, int c, bit border);
      if (border) begin
        if (r == 0 || c == 0 || r == in_rows + 1 || c == in_cols + 1) return 0;
        r--; c--;
      end
      return feat_mem[k * FEAT_PLANE + r * DEF_MAX_COLS + c];
    endfunction

    function bit run_layer();
      int orow, ocol, k, y, x, l, c, m, v, a;
      longint acc;
      bit border;
      if (!cur_shape(orow, ocol)) return 0;
      border = (op_mode == MODE_BORDER);
      for (k = 0; k < channels; k++)
        for (y = 0; y < orow; y++)
          for (x = 0; x < ocol; x++) begin
            a = k * RES_PLANE + y * RES_PITCH + x;
            if (op_mode == MODE_POOL) begin
              m = POOL_START;
              for (l = 0; l < win_rows; l++)
                for (c = 0; c < win_cols; c++) begin
                  v = pixel(k, y * win_rows + l, x * win_cols + c, 0);
                  if (v > m) m = v;
                end
              res_mem[a] = m <<< 8;
            end else begin
              acc = 0;
              for (l = 0; l < win_rows; l++)
                for (c = 0; c < win_cols; c++)
                  acc += longint'(pixel(k, y * (win_rows - 1) + l, x * (win_cols - 1) + c,
                                        border))
                         * longint'(filt_mem[k * FILT_PLANE + l * DEF_MAX_WINDOW + c]);
              if (acc > 64'sd2147483647) acc = 64'sd2147483647;
              if (acc < -64'sd2147483648) acc = -64'sd2147483648;
              res_mem[a] = acc[31:0];
            end
            res_ok[a] = 1;
          end
      res_rows = orow[5:0];
      res_cols = ocol[5:0];
      return 1;
    endfunction

    // Note an accepted command item and queue the response it owes.
    function void note_cmd(action_t act, logic [INDEX_W-1:0] idx, logic signed [VALUE_W-1:0] v);
      layer_rsp_t e;
      e.data = '0;
      case (act)
        ACT_WR_FEAT: begin
          if (idx < FEAT_DEPTH) begin feat_mem[idx] = v; feat_ok[idx] = 1; end
          return;
        end
        ACT_WR_FILT: begin
          if (idx < FILT_DEPTH) begin filt_mem[idx] = v; filt_ok[idx] = 1; end
          return;
        end
        ACT_COMPUTE: begin
          n_compute++;
          if (run_layer()) e.status = ST_DONE;
          else begin e.status = ST_ERR; n_shape_err++; end
        end
        default: begin
          n_read++;
          e.status = ST_READ;
          if (idx < RES_DEPTH) e.data = res_mem[idx];
        end
      endcase
      e.rows = res_rows;
      e.cols = res_cols;
      owed_q.push_back(e);
    endfunction

    function void check_rsp(logic signed [DATA_W-1:0] data, logic [STATUS_W-1:0] status,
                            logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
      layer_rsp_t e;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected response data=%0d status=%0d", $time, data, status);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (data !== e.data) begin
        $display("%0t: data expected %0d actual %0d", $time, e.data, data); errors++;
      end
      if (status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, status); errors++;
      end
      if (rows !== e.rows) begin
        $display("%0t: out_rows expected %0d actual %0d", $time, e.rows, rows); errors++;
      end
      if (cols !== e.cols) begin
        $display("%0t: out_cols expected %0d actual %0d", $time, e.cols, cols); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  dcm_cmd_if cmd_ch ();
  dcm_rsp_if rsp_ch ();
  dcm_cfg_if cfg_ch ();

  depthwise_conv_maxpool_engine_unit uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  conv_pool_scoreboard sb;
  bit idle_on = 1'b1;
  int n_sent = 0;
  int n_phases = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Response side: check every accepted item, then decide whether to stall.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_rsp(rsp_ch.data, rsp_ch.status, rsp_ch.out_rows, rsp_ch.out_cols);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 19) - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Watchdog: any handshake on any channel resets the count.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one command item; with idling on, sometimes hold valid low for a random burst first.
  task automatic send_cmd(action_t act, int idx, logic signed [VALUE_W-1:0] v);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    cmd_ch.valid  <= 1'b1;
    cmd_ch.action <= act;
    cmd_ch.index  <= idx[INDEX_W-1:0];
    cmd_ch.value  <= v;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_cmd(act, idx[INDEX_W-1:0], v);
    n_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, d[CFG_DATA_W-1:0]);
  endtask

  // Drop valid and wait out every owed response plus the tail of a write.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value(int fill, bit is_weight);
    case (fill)
      1: return 16'sh7FFF;
      2: return is_weight ? 16'sh7FFF : 16'sh8000;
      3: return 16'sh8000;
      default: return VALUE_W'($urandom());
    endcase
  endfunction

  // Write the layer's unwritten operands and rewrite some at random; all for a fixed fill.
  task automatic load_operands(int fill);
    int orow, ocol, k, r, c, a;
    if (!sb.cur_shape(orow, ocol)) return;
    for (k = 0; k < sb.channels; k++)
      for (r = 0; r < sb.in_rows; r++)
        for (c = 0; c < sb.in_cols; c++) begin
          a = k * FEAT_PLANE + r * DEF_MAX_COLS + c;
          if (fill != 0 || !sb.feat_ok[a] || $urandom_range(0, 7) == 0)
            send_cmd(ACT_WR_FEAT, a, pick_value(fill, 0));
        end
    if (sb.op_mode == MODE_POOL) return;
    for (k = 0; k < sb.channels; k++)
      for (r = 0; r < sb.win_rows; r++)
        for (c = 0; c < sb.win_cols; c++) begin
          a = k * FILT_PLANE + r * DEF_MAX_WINDOW + c;
          if (fill != 0 || !sb.filt_ok[a] || $urandom_range(0, 3) == 0)
            send_cmd(ACT_WR_FILT, a, pick_value(fill, 1));
        end
  endtask

  // Read back results: mostly the fresh plane, some stale entries, some beyond the store.
  task automatic read_results(int n);
    int i, sel, a, tries;
    for (i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      a = RES_DEPTH + $urandom_range(0, 16383 - RES_DEPTH);
      if (sel < 7 && sb.res_rows != 0 && sb.res_cols != 0) begin
        a = $urandom_range(0, sb.channels - 1) * RES_PLANE
          + $urandom_range(0, sb.res_rows - 1) * RES_PITCH + $urandom_range(0, sb.res_cols - 1);
        if (!sb.res_ok[a]) a = RES_DEPTH;
      end else if (sel < 9) begin
        for (tries = 0; tries < 40; tries++) begin
          a = $urandom_range(0, RES_DEPTH - 1);
          if (sb.res_ok[a]) break;
        end
        if (!sb.res_ok[a]) a = 16383;
      end
      send_cmd(ACT_READ, a, VALUE_W'($urandom()));
    end
  endtask

  // Stray writes anywhere in the address space, most of them ignored by the block.
  task automatic stray_writes(int n);
    repeat (n)
      send_cmd($urandom_range(0, 1) ? ACT_WR_FEAT : ACT_WR_FILT, $urandom_range(0, 16383),
               VALUE_W'($urandom()));
  endtask

  // One configuration phase: program the shape, load, compute, read back.
  task automatic run_phase(int op, int r, int c, int ch, int wr, int wc, int fill);
    drain();
    write_reg(REG_OP_MODE, op);
    write_reg(REG_IN_ROWS, r);
    write_reg(REG_IN_COLS, c);
    write_reg(REG_CHANNELS, ch);
    write_reg(REG_WIN_ROWS, wr);
    write_reg(REG_WIN_COLS, wc);
    cfg_ch.valid <= 1'b0;
    n_phases++;
    load_operands(fill);
    if ($urandom_range(0, 3) == 0) stray_writes($urandom_range(1, 4));
    send_cmd(ACT_COMPUTE, $urandom_range(0, 16383), VALUE_W'($urandom()));
    read_results($urandom_range(3, 12));
    if ($urandom_range(0, 4) == 0) begin
      load_operands(0);
      send_cmd(ACT_COMPUTE, $urandom_range(0, 16383), VALUE_W'($urandom()));
      read_results($urandom_range(2, 6));
    end
  endtask

  // Pick a shape: mostly legal and small, now and then large or raw register noise.
  task automatic random_phase();
    int op, r, c, ch, wr, wc, orow, ocol, tries;
    bit big;
    if ($urandom_range(0, 9) == 0) begin
      run_phase($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15), 0);
      return;
    end
    big = ($urandom_range(0, 24) == 0);
    for (tries = 0; tries < 500; tries++) begin
      op = $urandom_range(0, 2);
      r  = $urandom_range(1, big ? 32 : 10);
      c  = $urandom_range(1, big ? 32 : 10);
      ch = $urandom_range(1, big ? 8 : 3);
      wr = $urandom_range(op == MODE_POOL ? 1 : 2, big ? 8 : 5);
      wc = $urandom_range(op == MODE_POOL ? 1 : 2, big ? 8 : 5);
      if (sb.shape_of(op, r, c, ch, wr, wc, orow, ocol) && (big || r * c * ch <= 150)
          && ch * r * c <= 300)
        break;
    end
    run_phase(op, r, c, ch, wr, wc, $urandom_range(0, 19) == 0 ? $urandom_range(1, 3) : 0);
  endtask

  initial begin
    sb = new();
    cmd_ch.valid = 1'b0;
    cmd_ch.action = ACT_WR_FEAT;
    cmd_ch.index = '0;
    cmd_ch.value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rsp_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset shape: 1x1 input under a 2x2 filter gives an empty result plane.
    send_cmd(ACT_COMPUTE, 0, 16'sh0000);
    send_cmd(ACT_READ, 16383, 16'sh7FFF);
    send_cmd(ACT_WR_FEAT, 16383, 16'sh8000);
    send_cmd(ACT_WR_FILT, FILT_DEPTH - 1, 16'sh7FFF);
    send_cmd(ACT_WR_FILT, 16383, 16'shFFFF);

    // Saturation both ways, pooling floor, largest rows, columns, windows and
    // channel count, shape errors.
    run_phase(MODE_CONV, 8, 8, 1, 8, 8, 1);
    run_phase(MODE_CONV, 8, 8, 1, 8, 8, 2);
    run_phase(MODE_POOL, 4, 4, 1, 2, 2, 3);
    run_phase(MODE_BORDER, 32, 4, 1, 2, 2, 0);
    run_phase(MODE_POOL, 4, 32, 1, 4, 8, 0);
    run_phase(MODE_POOL, 2, 2, 8, 1, 1, 0);
    run_phase(3, 4, 4, 1, 2, 2, 0);
    run_phase(MODE_CONV, 0, 5, 1, 2, 2, 0);
    run_phase(MODE_CONV, 33, 63, 9, 2, 2, 0);
    run_phase(MODE_CONV, 5, 5, 0, 2, 2, 0);
    run_phase(MODE_CONV, 5, 5, 1, 1, 2, 0);
    run_phase(MODE_POOL, 5, 5, 1, 2, 2, 0);
    run_phase(MODE_CONV, 6, 5, 1, 3, 3, 0);
    run_phase(MODE_POOL, 3, 3, 1, 0, 15, 0);
    run_phase(MODE_POOL, 3, 3, 1, 9, 1, 0);
    run_phase(MODE_CONV, 1, 1, 1, 8, 8, 0);

    while (n_sent < ITEM_TARGET || sb.n_read < 60) begin
      if (n_sent > ITEM_TARGET * 85 / 100) idle_on = 1'b0;
      random_phase();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d command items over %0d shape settings: %0d computes (%0d shape errors),",
             n_sent, n_phases, sb.n_compute, sb.n_shape_err);
    $display("%0d result reads; %0d mismatches.", sb.n_read, sb.errors);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
